>>> rtl/fct_pkg.sv
//------------------------------------------------------------------------------
// fct_pkg
// Shared types and codes for the fault code table.
//------------------------------------------------------------------------------
package fct_pkg;

	localparam logic [2:0] CMD_ADD   = 3'd0;
	localparam logic [2:0] CMD_ERASE = 3'd1;
	localparam logic [2:0] CMD_ERASM = 3'd2;
	localparam logic [2:0] CMD_TICK  = 3'd3;
	localparam logic [2:0] CMD_QUERY = 3'd4;
	localparam logic [2:0] CMD_LIST  = 3'd5;

	localparam logic [1:0] KIND_EVENT = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_LIST  = 2'd2;
	localparam logic [1:0] KIND_FULL  = 2'd3;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  addr;
		logic [18:0] spn;
		logic [4:0]  fmi;
		logic [15:0] tmo;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  addr;
		logic [18:0] spn;
		logic [4:0]  fmi;
		logic        act;
		logic        match;
		logic        last;
	} res_t;

endpackage

>>> rtl/fct_front.sv
//------------------------------------------------------------------------------
// fct_front
// Input stage and a two-entry command queue toward the table engine.
//------------------------------------------------------------------------------
module fct_front
	import fct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cmd_t        in_cmd,
	output logic        q_valid,
	input  logic        q_ready,
	output cmd_t        q_cmd
);

	cmd_t       buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = buf_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> rtl/fct_back.sv
//------------------------------------------------------------------------------
// fct_back
// Table engine: walks the slots one per cycle, holding while a result beat waits on the output, and emits result beats.
//------------------------------------------------------------------------------
module fct_back
	import fct_pkg::*;
#(
	parameter int TABLE_ENTRIES = 32,
	parameter int COUNT_BITS    = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  cmd_t q_cmd,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] LASTI = CW'(TABLE_ENTRIES - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_WALK = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [TABLE_ENTRIES-1:0] used_q, act_q, hto_q;
	logic [7:0]            sa_q  [TABLE_ENTRIES];
	logic [18:0]           ss_q  [TABLE_ENTRIES];
	logic [4:0]            sf_q  [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0] cd_q  [TABLE_ENTRIES];

	logic [2:0]    st_q;
	cmd_t          c_q;
	logic [CW-1:0] i_q;
	logic          hit_q, fu_q, fi_q;
	logic [IW-1:0] hs_q, us_q, is_q;
	logic          pend_q;   // a found result held back that may still be followed
	res_t          pres_q;
	logic          ov_q;
	res_t          ores_q;

	logic [IW-1:0] ix;
	logic          keyhit;
	logic [COUNT_BITS-1:0] tsat;

	assign ix = i_q[IW-1:0];
	assign keyhit = used_q[ix] && sa_q[ix] == c_q.addr && ss_q[ix] == c_q.spn;
	generate
		if (COUNT_BITS >= 16) begin : g_w
			assign tsat = COUNT_BITS'(c_q.tmo);
		end else begin : g_n
			logic sat_ov;
			assign sat_ov = |c_q.tmo[15:COUNT_BITS];
			assign tsat = sat_ov ? {COUNT_BITS{1'b1}} : c_q.tmo[COUNT_BITS-1:0];
		end
	endgenerate

	assign q_ready   = (st_q == ST_IDLE);
	assign out_valid = ov_q;
	assign out_res   = ores_q;

	// output register: free when empty or taken this cycle
	logic ofree;
	assign ofree = !ov_q || out_ready;

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) c_q <= q_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic ov_d;
		res_t ores_d;
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			used_q <= '0;
			act_q  <= '0;
			hto_q  <= '0;
			ov_q   <= 1'b0;
			pend_q <= 1'b0;
			i_q    <= '0;
		end else begin
			ov_d   = ov_q && !out_ready;
			ores_d = ores_q;
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						i_q   <= '0;
						hit_q <= 1'b0;
						fu_q  <= 1'b0;
						fi_q  <= 1'b0;
						pend_q <= 1'b0;
						if (q_cmd.cmd == CMD_TICK || q_cmd.cmd == CMD_LIST) st_q <= ST_WALK;
						else if (q_cmd.cmd <= CMD_QUERY) st_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (keyhit && !hit_q) begin hit_q <= 1'b1; hs_q <= ix; end
					if (!used_q[ix] && !fu_q) begin fu_q <= 1'b1; us_q <= ix; end
					if (!act_q[ix] && !fi_q) begin fi_q <= 1'b1; is_q <= ix; end
					i_q <= i_q + 1'b1;
					if (i_q == LASTI) st_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (ofree) begin
						ores_d.addr  = c_q.addr;
						ores_d.spn   = c_q.spn;
						ores_d.match = 1'b0;
						ores_d.last  = 1'b1;
						st_q <= ST_IDLE;
						case (c_q.cmd)
							CMD_ADD: begin
								if (!hit_q && !fu_q && !fi_q) begin
									ov_d = 1'b1;
									ores_d.kind = KIND_FULL;
									ores_d.fmi  = c_q.fmi;
									ores_d.act  = 1'b0;
								end else begin
									logic [IW-1:0] s;
									s = hit_q ? hs_q : (fu_q ? us_q : is_q);
									used_q[s] <= 1'b1;
									sa_q[s] <= c_q.addr;
									ss_q[s] <= c_q.spn;
									sf_q[s] <= c_q.fmi;
									hto_q[s] <= |c_q.tmo;
									cd_q[s] <= tsat;
									act_q[s] <= 1'b1;
									if (hit_q && act_q[s] && sf_q[s] != c_q.fmi) begin
										ov_d = 1'b1;
										ores_d.kind = KIND_EVENT;
										ores_d.fmi  = sf_q[s];
										ores_d.act  = 1'b0;
										ores_d.last = 1'b0;
										pres_q.fmi  <= c_q.fmi;
										st_q <= ST_OUT;
									end else if (!(hit_q && act_q[s])) begin
										ov_d = 1'b1;
										ores_d.kind = KIND_EVENT;
										ores_d.fmi  = c_q.fmi;
										ores_d.act  = 1'b1;
									end
								end
							end
							CMD_ERASE, CMD_ERASM: begin
								if (hit_q && (c_q.cmd == CMD_ERASE || sf_q[hs_q] == c_q.fmi)) begin
									hto_q[hs_q] <= 1'b1;
									cd_q[hs_q]  <= '0;
								end
							end
							default: begin
								ov_d = 1'b1;
								ores_d.kind = KIND_QUERY;
								if (hit_q && act_q[hs_q]) begin
									ores_d.fmi   = sf_q[hs_q];
									ores_d.act   = 1'b1;
									ores_d.match = sf_q[hs_q] == c_q.fmi;
								end else begin
									ores_d.fmi = '0;
									ores_d.act = 1'b0;
								end
							end
						endcase
					end
				end
				ST_OUT: begin
					if (ofree) begin
						ov_d = 1'b1;
						ores_d.kind  = KIND_EVENT;
						ores_d.fmi   = pres_q.fmi;
						ores_d.act   = 1'b1;
						ores_d.match = 1'b0;
						ores_d.last  = 1'b1;
						st_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					// a found result is held one step so the final one gets last
					if (i_q == CW'(TABLE_ENTRIES)) begin
						if (ofree) begin
							if (pend_q) begin
								ov_d = 1'b1;
								ores_d = pres_q;
								ores_d.last = 1'b1;
							end
							st_q <= ST_IDLE;
						end
					end else begin
						logic fire, emit;
						fire = used_q[ix] && act_q[ix] &&
							(c_q.cmd == CMD_LIST || (hto_q[ix] && cd_q[ix] == '0));
						emit = fire && pend_q;
						if (!emit || ofree) begin
							if (emit) begin
								ov_d = 1'b1;
								ores_d = pres_q;
							end
							if (fire) begin
								pend_q <= 1'b1;
								pres_q.kind <= (c_q.cmd == CMD_LIST) ? KIND_LIST : KIND_EVENT;
								pres_q.addr <= sa_q[ix];
								pres_q.spn  <= ss_q[ix];
								pres_q.fmi  <= sf_q[ix];
								pres_q.act  <= (c_q.cmd == CMD_LIST);
								pres_q.match <= 1'b0;
								pres_q.last <= 1'b0;
							end
							if (c_q.cmd == CMD_TICK && used_q[ix] && act_q[ix] && hto_q[ix]) begin
								if (cd_q[ix] != '0) cd_q[ix] <= cd_q[ix] - 1'b1;
								else act_q[ix] <= 1'b0;
							end
							i_q <= i_q + 1'b1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			ov_q   <= ov_d;
			ores_q <= ores_d;
		end
	end

endmodule

>>> rtl/fault_code_table_with_timeout.sv
//------------------------------------------------------------------------------
// fault_code_table_with_timeout
// Active fault code table keyed by address and SPN, with per-entry timeout.
//------------------------------------------------------------------------------
// Commands enter on the s_axis channel, results leave on m_axis.
// s_axis_tdata: cmd, src_address, spn_in, fmi_in, timeout_ticks (low bits up).
// m_axis_tdata: out_address, out_spn, out_fmi, is_active, fmi_matches;
// m_axis_tuser: kind; m_axis_tlast marks the final beat of one command.
// A two-entry queue takes commands while the engine is busy.
// Add, erase and query scan the table one slot a cycle, then act; an add that
// replaces an active FMI emits a second beat. Tick and list walk every slot once.
// Reset empties the table and the queue. When m_axis_tready is low the engine
// holds its walk; the queue fills and then s_axis_tready drops.
//------------------------------------------------------------------------------
module fault_code_table_with_timeout
	import fct_pkg::*;
#(
	parameter int TABLE_ENTRIES = 32,
	parameter int COUNT_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // cmd, src_address, spn_in, fmi_in, timeout_ticks
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // out_address, out_spn, out_fmi, is_active, fmi_matches
	output logic [1:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast
);

	cmd_t in_cmd, q_cmd;
	res_t res;
	logic q_valid, q_ready;

	assign in_cmd.cmd  = s_axis_tdata[2:0];
	assign in_cmd.addr = s_axis_tdata[10:3];
	assign in_cmd.spn  = s_axis_tdata[29:11];
	assign in_cmd.fmi  = s_axis_tdata[34:30];
	assign in_cmd.tmo  = s_axis_tdata[50:35];

	fct_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	fct_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_cmd,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	assign m_axis_tdata = {6'd0, res.match, res.act, res.fmi, res.spn, res.addr};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

	a_query_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_QUERY |-> m_axis_tlast)
		else $error("query answer without last");
	a_full_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_FULL |-> m_axis_tlast && !m_axis_tdata[32])
		else $error("bad rejected add beat");
	a_match_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tuser == KIND_QUERY && m_axis_tdata[32])
		else $error("fmi match outside an active query");

endmodule

>>> sim/fault_code_table_with_timeout_tb.sv
//------------------------------------------------------------------------------
// fault_code_table_with_timeout_tb
// Drives add, erase, tick, query and list commands into the fault code table
// and checks every result beat against a behavioral table kept in the bench.
//------------------------------------------------------------------------------
module fault_code_table_with_timeout_tb;
	import fct_pkg::*;

	localparam int N_SLOTS = 32;
	localparam int LIMIT   = 400000;

	// command codes the block ignores
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	fault_code_table_with_timeout dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// table model
	bit        used [N_SLOTS];
	bit [7:0]  t_addr [N_SLOTS];
	bit [18:0] t_spn [N_SLOTS];
	bit [4:0]  t_fmi [N_SLOTS];
	bit        active [N_SLOTS];
	bit        has_tmo [N_SLOTS];
	bit [15:0] countdown [N_SLOTS];

	cmd_t cmd_q [$];
	res_t result_q [$];
	int   errors = 0;
	int   send_idle = 0;
	int   recv_idle = 0;
	int   hold_off = 0;
	bit   hold_req = 1'b0;
	bit   done = 1'b0;
	int   cycles = 0;

	function automatic void enq(cmd_t c);
		cmd_q.insert(cmd_q.size(), c);
	endfunction

	function automatic int find_key(bit [7:0] a, bit [18:0] s);
		for (int i = 0; i < N_SLOTS; i++)
			if (used[i] && t_addr[i] == a && t_spn[i] == s)
				return i;
		return -1;
	endfunction

	function automatic void push_res(logic [1:0] k, bit [7:0] a, bit [18:0] s, bit [4:0] f,
			bit act, bit m);
		res_t r;
		r.kind = k; r.addr = a; r.spn = s; r.fmi = f;
		r.act = act; r.match = m; r.last = 1'b0;
		result_q.insert(result_q.size(), r);
	endfunction

	function automatic void apply_cmd(cmd_t c);
		int s;
		int n0;
		n0 = result_q.size();
		case (c.cmd)
			CMD_ADD: begin
				s = find_key(c.addr, c.spn);
				if (s < 0) begin
					for (int i = 0; i < N_SLOTS && s < 0; i++)
						if (!used[i]) s = i;
					for (int i = 0; i < N_SLOTS && s < 0; i++)
						if (!active[i]) s = i;
					if (s < 0) begin
						push_res(KIND_FULL, c.addr, c.spn, c.fmi, 0, 0);
					end else begin
						used[s] = 1; t_addr[s] = c.addr; t_spn[s] = c.spn;
						t_fmi[s] = 0; active[s] = 0; has_tmo[s] = 0; countdown[s] = 0;
					end
				end
				if (s >= 0) begin
					if (active[s] && t_fmi[s] != c.fmi) begin
						active[s] = 0;
						push_res(KIND_EVENT, c.addr, c.spn, t_fmi[s], 0, 0);
					end
					has_tmo[s] = c.tmo != 0;
					if (c.tmo != 0) countdown[s] = c.tmo;
					t_fmi[s] = c.fmi;
					if (!active[s]) begin
						active[s] = 1;
						push_res(KIND_EVENT, c.addr, c.spn, c.fmi, 1, 0);
					end
				end
			end
			CMD_ERASE, CMD_ERASM: begin
				s = find_key(c.addr, c.spn);
				if (s >= 0 && (c.cmd == CMD_ERASE || t_fmi[s] == c.fmi)) begin
					has_tmo[s] = 1; countdown[s] = 0;
				end
			end
			CMD_TICK: begin
				for (int i = 0; i < N_SLOTS; i++) begin
					if (used[i] && active[i] && has_tmo[i]) begin
						if (countdown[i] != 0) begin
							countdown[i]--;
						end else begin
							active[i] = 0;
							push_res(KIND_EVENT, t_addr[i], t_spn[i], t_fmi[i], 0, 0);
						end
					end
				end
			end
			CMD_QUERY: begin
				s = find_key(c.addr, c.spn);
				if (s >= 0 && active[s])
					push_res(KIND_QUERY, c.addr, c.spn, t_fmi[s], 1, t_fmi[s] == c.fmi);
				else
					push_res(KIND_QUERY, c.addr, c.spn, 0, 0, 0);
			end
			CMD_LIST: begin
				for (int i = 0; i < N_SLOTS; i++)
					if (used[i] && active[i])
						push_res(KIND_LIST, t_addr[i], t_spn[i], t_fmi[i], 1, 0);
			end
			default: ;
		endcase
		if (result_q.size() > n0)
			result_q[$].last = 1'b1;
	endfunction

	// driver: next command from cmd_q, with random gaps
	always @(posedge clk) begin
		cmd_t c;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				{c.tmo, c.fmi, c.spn, c.addr, c.cmd} = s_axis_tdata[50:0];
				apply_cmd(c);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					c = cmd_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {5'd0, c.tmo, c.fmi, c.spn, c.addr, c.cmd};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted in cycles
	always @(posedge clk) begin
		if (hold_off > 0)
			hold_off <= hold_off - 1;
		else if (hold_req)
			hold_off <= 600;
	end

	// monitor
	always @(posedge clk) begin
		res_t exp_r;
		res_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser;
				{got.match, got.act, got.fmi, got.spn, got.addr} = m_axis_tdata[33:0];
				got.last = m_axis_tlast;
				if (result_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat %h", $time, got);
				end else begin
					exp_r = result_q.pop_front();
					if (got !== exp_r) begin
						errors++;
						$display("%0t: expected %h got %h", $time, exp_r, got);
					end
				end
			end
			if (hold_off > 0 || hold_req)
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= $urandom_range(99) >= recv_idle;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT && !done) begin
			$display("fault_code_table_with_timeout_tb: done, errors");
			$finish;
		end
	end

	function automatic cmd_t rand_cmd(bit well_formed);
		cmd_t c;
		c.cmd  = well_formed ? 3'($urandom_range(5)) : 3'($urandom_range(7));
		c.addr = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3));
		c.spn  = $urandom_range(3) == 0 ? 19'($urandom) : 19'($urandom_range(7) << 16);
		c.fmi  = $urandom_range(1) ? 5'($urandom) : 5'($urandom_range(1));
		c.tmo  = $urandom_range(2) == 0 ? 16'($urandom) : 16'($urandom_range(4));
		if (c.cmd == CMD_TICK && $urandom_range(1)) c.cmd = CMD_TICK;
		return c;
	endfunction

	task automatic drain();
		while (cmd_q.size() > 0 || s_axis_tvalid || result_q.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		cmd_t c;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, each command, replace FMI, erase cases, absent key
		enq('{CMD_LIST, 8'h00, 19'h0, 5'h00, 16'h0});
		enq('{CMD_QUERY, 8'hFF, 19'h7FFFF, 5'h1F, 16'h0});
		enq('{CMD_ADD, 8'hFF, 19'h7FFFF, 5'h1F, 16'hFFFF});
		enq('{CMD_ADD, 8'h00, 19'h0, 5'h00, 16'h0});
		enq('{CMD_ADD, 8'h00, 19'h0, 5'h00, 16'h1});
		enq('{CMD_ADD, 8'h00, 19'h0, 5'h15, 16'h2});
		enq('{CMD_QUERY, 8'h00, 19'h0, 5'h15, 16'h0});
		enq('{CMD_QUERY, 8'h00, 19'h0, 5'h0A, 16'h0});
		enq('{CMD_TICK, 8'h00, 19'h0, 5'h00, 16'h0});
		enq('{CMD_ERASM, 8'hFF, 19'h7FFFF, 5'h01, 16'h0});
		enq('{CMD_ERASM, 8'hFF, 19'h7FFFF, 5'h1F, 16'h0});
		enq('{CMD_ERASE, 8'h12, 19'h345, 5'h00, 16'h0});
		enq('{CMD_LIST, 8'h00, 19'h0, 5'h00, 16'h0});
		enq('{CMD_TICK, 8'h00, 19'h0, 5'h00, 16'h0});
		enq('{CMD_TICK, 8'h00, 19'h0, 5'h00, 16'h0});
		enq('{CMD_TICK, 8'h00, 19'h0, 5'h00, 16'h0});
		enq('{CMD_SPARE_A, 8'h01, 19'h1, 5'h01, 16'h0});
		enq('{CMD_SPARE_B, 8'h01, 19'h1, 5'h01, 16'h0});
		// fill the table past capacity, then list
		for (int i = 0; i < 34; i++)
			enq('{CMD_ADD, 8'(i), 19'(i * 4099), 5'(i), 16'h0});
		enq('{CMD_ERASE, 8'd5, 19'(5 * 4099), 5'd0, 16'h0});
		enq('{CMD_TICK, 8'h00, 19'h0, 5'h00, 16'h0});
		enq('{CMD_ADD, 8'hAA, 19'h55555, 5'h0A, 16'h0});
		enq('{CMD_LIST, 8'h00, 19'h0, 5'h00, 16'h0});
		drain();

		// long receiver hold-off while lists keep the queue full
		hold_req = 1'b1;
		wait (hold_off > 0);
		hold_req = 1'b0;
		for (int i = 0; i < 6; i++)
			enq('{CMD_LIST, 8'h00, 19'h0, 5'h00, 16'h0});
		drain();

		// clear the table out with erases and a tick
		for (int i = 0; i < N_SLOTS; i++)
			if (used[i]) enq('{CMD_ERASE, t_addr[i], t_spn[i], 5'd0, 16'h0});
		enq('{CMD_TICK, 8'h00, 19'h0, 5'h00, 16'h0});
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 47 : 30) : 0;
			recv_idle = (ph == 2 || ph == 3) ? (ph == 2 ? 47 : 30) : 0;
			for (int i = 0; i < 45; i++) begin
				c = rand_cmd($urandom_range(9) != 0);
				enq(c);
			end
			drain();
		end

		done = 1'b1;
		if (errors == 0)
			$display("fault_code_table_with_timeout_tb: done, clean");
		else
			$display("fault_code_table_with_timeout_tb: done, errors");
		$finish;
	end

endmodule
